/* rtl/dsp_pkg.sv */
package dsp_pkg;

  // Field widths of the text stream and of the parsed result.
  localparam int CHAR_W = 8;
  localparam int MANT_W = 64;
  localparam int EXP_W  = 16;
  localparam int CNT_W  = 16;

  // Snapshot of the parse state at the end of a string.
  typedef struct packed {
    logic                     ok;
    logic signed [MANT_W-1:0] mant;
    logic signed [EXP_W-1:0]  expo;
    logic [CNT_W-1:0]         cnt;
  } acc_snap_t;

  // One parsed result item.
  typedef struct packed {
    logic                     valid_res;
    logic signed [MANT_W-1:0] mantissa;
    logic signed [EXP_W-1:0]  exponent;
    logic [CNT_W-1:0]         consumed;
  } result_t;

endpackage

/* rtl/dsp_in_if.sv */
interface dsp_in_if import dsp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink (input valid, character, last_char, output ready);
endinterface

/* rtl/dsp_out_if.sv */
interface dsp_out_if import dsp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     valid_res;
  logic signed [MANT_W-1:0] mantissa;
  logic signed [EXP_W-1:0]  exponent;
  logic [CNT_W-1:0]         consumed;

  modport source (output valid, valid_res, mantissa, exponent, consumed, input ready);
  modport sink (input valid, valid_res, mantissa, exponent, consumed, output ready);
endinterface

/* rtl/dsp_accum.sv */
module dsp_accum import dsp_pkg::*; #(
  parameter int unsigned MAX_CHARS = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] character,
  input  logic              clear,
  output acc_snap_t         snap
);

  localparam logic [1:0] PH_WS     = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_END    = 2'd2;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  localparam logic signed [MANT_W-1:0] MANT_LIM = 64'sd922337203685477580;
  localparam logic signed [EXP_W-1:0]  EXP_MAX  = 16'sh7FFF;
  localparam logic signed [EXP_W-1:0]  EXP_MIN  = 16'sh8000;
  localparam logic [CNT_W-1:0]         CNT_LIM  = CNT_W'(MAX_CHARS);

  logic [1:0]               phase_r, phase_nxt;
  logic                     neg_r, neg_nxt;
  logic                     frac_r, frac_nxt;
  logic                     seen_r, seen_nxt;
  logic                     bad_r, bad_nxt;
  logic signed [MANT_W-1:0] mant_r, mant_nxt;
  logic signed [EXP_W-1:0]  exp_r, exp_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic                     is_dig;
  logic                     is_blank;
  logic                     take_dig;
  logic                     cons;
  logic                     ovf;
  logic signed [MANT_W-1:0] sdig;
  logic signed [MANT_W-1:0] mant_mac;

  // Character classes.
  assign is_dig   = (character >= CH_ZERO) && (character <= CH_NINE);
  assign is_blank = (character == CH_SPACE) || (character == CH_TAB) ||
                    (character == CH_LF) || (character == CH_CR);

  // Multiply-accumulate by ten with the sign applied to the new digit.
  assign sdig     = neg_r ? -$signed({60'd0, character[3:0]})
                          : $signed({60'd0, character[3:0]});
  assign mant_mac = (mant_r <<< 3) + (mant_r <<< 1) + sdig;
  assign ovf      = (mant_r < -MANT_LIM) || (mant_r > MANT_LIM);

  // Next parse state for the current character.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    frac_nxt  = frac_r;
    seen_nxt  = seen_r;
    bad_nxt   = bad_r;
    mant_nxt  = mant_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    take_dig  = 1'b0;
    cons      = 1'b0;

    if (step) begin
      case (phase_r)
        PH_WS: begin
          if (character == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_DIGITS;
            cons      = 1'b1;
          end else if (character == CH_PLUS) begin
            phase_nxt = PH_DIGITS;
            cons      = 1'b1;
          end else if (character == CH_POINT) begin
            frac_nxt  = 1'b1;
            phase_nxt = PH_DIGITS;
            cons      = 1'b1;
          end else if (is_dig) begin
            phase_nxt = PH_DIGITS;
            take_dig  = 1'b1;
          end else if (is_blank) begin
            cons = 1'b1;
          end else begin
            bad_nxt   = 1'b1;
            phase_nxt = PH_END;
          end
        end
        PH_DIGITS: begin
          if (character == CH_POINT) begin
            if (!frac_r) begin
              frac_nxt = 1'b1;
              cons     = 1'b1;
            end else begin
              phase_nxt = PH_END;
            end
          end else if (is_dig) begin
            take_dig = 1'b1;
          end else begin
            phase_nxt = PH_END;
          end
        end
        default: begin
          // The parse has ended; later characters are ignored.
        end
      endcase
    end

    // A digit either grows the mantissa or, once it is too large, only
    // moves the exponent for integer digits.
    if (take_dig) begin
      seen_nxt = 1'b1;
      cons     = 1'b1;
      if (ovf) begin
        if (!frac_r && (exp_r != EXP_MAX)) begin
          exp_nxt = exp_r + 16'sd1;
        end
      end else begin
        mant_nxt = mant_mac;
        if (frac_r && (exp_r != EXP_MIN)) begin
          exp_nxt = exp_r - 16'sd1;
        end
      end
    end

    if (cons && (cnt_r < CNT_LIM)) begin
      cnt_nxt = cnt_r + 16'd1;
    end

    if (clear) begin
      phase_nxt = PH_WS;
      neg_nxt   = 1'b0;
      frac_nxt  = 1'b0;
      seen_nxt  = 1'b0;
      bad_nxt   = 1'b0;
      mant_nxt  = '0;
      exp_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      neg_r   <= 1'b0;
      frac_r  <= 1'b0;
      seen_r  <= 1'b0;
      bad_r   <= 1'b0;
      mant_r  <= '0;
      exp_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      frac_r  <= frac_nxt;
      seen_r  <= seen_nxt;
      bad_r   <= bad_nxt;
      mant_r  <= mant_nxt;
      exp_r   <= exp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign snap.ok   = seen_r && !bad_r;
  assign snap.mant = mant_r;
  assign snap.expo = exp_r;
  assign snap.cnt  = cnt_r;

endmodule

/* rtl/dsp_div10.sv */
module dsp_div10 import dsp_pkg::*; (
  input  logic [3:0]        rem_in,
  input  logic [CHAR_W-1:0] dividend,
  output logic [CHAR_W-1:0] quo,
  output logic [3:0]        rem_out
);

  logic [7:0]  v_hi, v_lo;
  logic [15:0] p_hi, p_lo;
  logic [3:0]  q_hi, q_lo;
  logic [7:0]  x_hi, x_lo;
  logic [7:0]  d_hi, d_lo;
  logic [3:0]  r_hi;

  // Upper nibble: the partial value stays below 160, so times 205 over
  // 2048 gives the exact quotient by ten.
  assign v_hi = {rem_in, dividend[7:4]};
  assign p_hi = 16'(v_hi) * 16'd205;
  assign q_hi = p_hi[14:11];
  assign x_hi = {1'b0, q_hi, 3'b000} + {3'b000, q_hi, 1'b0};
  assign d_hi = v_hi - x_hi;
  assign r_hi = d_hi[3:0];

  // Lower nibble, same step on the remainder of the upper one.
  assign v_lo = {r_hi, dividend[3:0]};
  assign p_lo = 16'(v_lo) * 16'd205;
  assign q_lo = p_lo[14:11];
  assign x_lo = {1'b0, q_lo, 3'b000} + {3'b000, q_lo, 1'b0};
  assign d_lo = v_lo - x_lo;

  assign quo     = {q_hi, q_lo};
  assign rem_out = d_lo[3:0];

endmodule

/* rtl/dsp_norm.sv */
module dsp_norm import dsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  acc_snap_t snap,
  input  logic      out_free,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_ABS   = 3'd1;
  localparam logic [2:0] N_CHECK = 3'd2;
  localparam logic [2:0] N_DIV   = 3'd3;
  localparam logic [2:0] N_HOLD  = 3'd4;

  localparam int DIV_STEPS = MANT_W / CHAR_W;
  localparam int IDX_W     = $clog2(DIV_STEPS);
  localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(DIV_STEPS - 1);
  localparam logic signed [EXP_W-1:0] EXP_CAP  = 16'sd63;

  logic [2:0]              state_r, state_nxt;
  logic                    ok_r, ok_nxt;
  logic                    neg_r, neg_nxt;
  logic [MANT_W-1:0]       mag_r, mag_nxt;
  logic [MANT_W-1:0]       wrk_r, wrk_nxt;
  logic signed [EXP_W-1:0] e_r, e_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [3:0]              rem_r, rem_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;

  logic [CHAR_W-1:0]       q_byte;
  logic [3:0]              q_rem;
  logic [MANT_W-1:0]       wrk_shift;

  // Shared divide-by-ten unit, eight bits of the magnitude per cycle.
  dsp_div10 u_div10 (
    .rem_in   (rem_r),
    .dividend (wrk_r[MANT_W-1 -: CHAR_W]),
    .quo      (q_byte),
    .rem_out  (q_rem)
  );

  assign wrk_shift = {wrk_r[MANT_W-CHAR_W-1:0], q_byte};

  // Sequencer: take magnitude, strip trailing zeros one digit at a time up to
  // exponent 63, then hold the result until the output register is free.
  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    wrk_nxt   = wrk_r;
    e_nxt     = e_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    done      = 1'b0;

    case (state_r)
      N_IDLE: begin
        if (start) begin
          ok_nxt    = snap.ok;
          mag_nxt   = snap.ok ? snap.mant : '0;
          e_nxt     = snap.ok ? snap.expo : '0;
          cnt_nxt   = snap.cnt;
          state_nxt = N_ABS;
        end
      end
      N_ABS: begin
        neg_nxt   = mag_r[MANT_W-1];
        mag_nxt   = mag_r[MANT_W-1] ? (~mag_r + 64'd1) : mag_r;
        state_nxt = N_CHECK;
      end
      N_CHECK: begin
        if (mag_r == '0) begin
          e_nxt     = '0;
          state_nxt = N_HOLD;
        end else if (e_r >= EXP_CAP) begin
          state_nxt = N_HOLD;
        end else begin
          wrk_nxt   = mag_r;
          rem_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = N_DIV;
        end
      end
      N_DIV: begin
        wrk_nxt = wrk_shift;
        rem_nxt = q_rem;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          if (q_rem == 4'd0) begin
            mag_nxt   = wrk_shift;
            e_nxt     = e_r + 16'sd1;
            state_nxt = N_CHECK;
          end else begin
            state_nxt = N_HOLD;
          end
        end
      end
      N_HOLD: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = N_IDLE;
        end
      end
      default: begin
        state_nxt = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ok_r  <= ok_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    wrk_r <= wrk_nxt;
    e_r   <= e_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
  end

  assign busy             = (state_r != N_IDLE);
  assign result.valid_res = ok_r;
  assign result.mantissa  = $signed(neg_r ? (~mag_r + 64'd1) : mag_r);
  assign result.exponent  = e_r;
  assign result.consumed  = cnt_r;

  // The running remainder of a division is always a decimal digit.
  a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == N_DIV) |-> (rem_r < 4'd10))
    else $error("division remainder out of range");

  // A result is only released into a free output register.
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_free)
    else $error("result released while output is occupied");

  // A new string end only arrives while the sequencer is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == N_IDLE))
    else $error("start while normalization busy");

  // A zero magnitude ends the loop with a zero exponent.
  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == N_CHECK && mag_r == '0) |=> (state_r == N_HOLD && e_r == '0))
    else $error("zero mantissa did not clear the exponent");

endmodule

/* rtl/decimal_string_parser_core.sv */
// Channel  Dir  Payload                                   Accepted when
// in_ch    in   character[7:0], last_char                 valid && ready
// out_ch   out  valid_res, mantissa[63:0], exponent[15:0],
//               consumed[15:0]                            valid && ready
//
// Characters are taken one per cycle while a string is being parsed.
// After the last character the input stalls while trailing zeros are
// removed; the shared divide-by-ten unit handles eight bits of the
// magnitude per cycle.
// A finished result waits in the output register; a new string is taken
// meanwhile, and only its end stalls until that register is free.
// Reset is synchronous and active low and returns the parser to the
// leading whitespace phase.
module decimal_string_parser_core import dsp_pkg::*; #(
  parameter int unsigned MAX_CHARS = 65535
) (
  input  logic      clk,
  input  logic      rst_n,
  dsp_in_if.sink    in_ch,
  dsp_out_if.source out_ch
);

  logic      in_acc;
  logic      start_r, start_nxt;
  logic      norm_busy;
  logic      norm_done;
  logic      out_free;
  logic      out_valid_r, out_valid_nxt;
  result_t   out_data_r;
  result_t   norm_res;
  acc_snap_t snap;

  // Input handshake; the parser rests while a string end is processed.
  assign in_ch.ready = !norm_busy && !start_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign start_nxt   = in_acc && in_ch.last_char;

  dsp_accum #(
    .MAX_CHARS (MAX_CHARS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .character (in_ch.character),
    .clear     (start_r),
    .snap      (snap)
  );

  dsp_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .snap     (snap),
    .out_free (out_free),
    .busy     (norm_busy),
    .done     (norm_done),
    .result   (norm_res)
  );

  // Output register.
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (norm_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (norm_done) begin
      out_data_r <= norm_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.valid_res = out_data_r.valid_res;
  assign out_ch.mantissa  = out_data_r.mantissa;
  assign out_ch.exponent  = out_data_r.exponent;
  assign out_ch.consumed  = out_data_r.consumed;

endmodule
